@@ sv/assert_macros.svh @@
// Assertion macros used by the checker file of the unescaper.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every clock edge outside reset.
`define JSU_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Check that a condition in one cycle implies another in the next cycle.
`define JSU_ASSERT_NEXT(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |=> (post)) else $error(msg);

`endif

@@ sv/jsu_pkg.sv @@
// Types and constants shared by the JSON string unescaper modules.
`default_nettype none

package jsu_pkg;

  // Results one input byte can cause, and the width of a count of them
  localparam int MaxResults = 4;
  localparam int CountW     = $clog2(MaxResults + 1);

  // Default depth of the result queue
  localparam int ResDepthDefault = 8;

  typedef enum logic [2:0] {
    MODE_IDLE,
    MODE_BODY,
    MODE_ESC,
    MODE_HEX,
    MODE_CONT
  } mode_e;

  typedef enum logic [3:0] {
    ST_DATA         = 4'd0,
    ST_DONE         = 4'd1,
    ST_NO_OPEN      = 4'd2,
    ST_UNTERMINATED = 4'd3,
    ST_DANGLING_ESC = 4'd4,
    ST_UNKNOWN_ESC  = 4'd5,
    ST_TRUNCATED_U  = 4'd6,
    ST_BAD_HEX      = 4'd7,
    ST_SURROGATE    = 4'd8,
    ST_CONTROL_BYTE = 4'd9,
    ST_BAD_UTF8     = 4'd10
  } status_e;

  // Control state of the decoder (held bytes live apart, without reset)
  typedef struct packed {
    mode_e       mode;
    logic [1:0]  hex_cnt;
    logic [20:0] code;
    logic [2:0]  seq_len;
    logic [1:0]  seq_rem;
  } core_state_t;

  typedef struct packed {
    logic [7:0] out_byte;
    status_e    status;
    logic       last;
  } res_t;

  typedef struct packed {
    logic [CountW-1:0]          count;
    res_t [MaxResults-1:0]      item;
  } res_bundle_t;

endpackage

`default_nettype wire

@@ sv/jsu_decode.sv @@
// Combinational step of the unescaper: next state and results for one byte.
`default_nettype none

module jsu_decode (
  input  jsu_pkg::core_state_t state_i,
  input  logic [2:0][7:0]      held_i,
  input  logic [7:0]           data_byte_i,
  input  logic                 end_of_input_i,
  output jsu_pkg::core_state_t state_o,
  output logic [2:0][7:0]      held_o,
  output jsu_pkg::res_bundle_t res_o
);

  localparam logic [20:0] CodeMax  = 21'h10FFFF;
  localparam logic [20:0] SurLo    = 21'h00D800;
  localparam logic [20:0] SurHi    = 21'h00DFFF;
  localparam logic [20:0] Min2     = 21'h000080;
  localparam logic [20:0] Min3     = 21'h000800;
  localparam logic [20:0] Min4     = 21'h010000;
  localparam logic [7:0]  Quote    = 8'h22;
  localparam logic [7:0]  Bslash   = 8'h5C;
  localparam logic [7:0]  Slash    = 8'h2F;
  localparam logic [7:0]  Del      = 8'h7F;

  logic                            fail;
  jsu_pkg::status_e                fail_st;
  logic [jsu_pkg::CountW-1:0]      cnt;
  logic [jsu_pkg::MaxResults-1:0][7:0] byt;
  logic [2:0]                      lead_len;
  logic [20:0]                     code_c;
  logic [1:0]                      idx;
  logic [1:0]                      rem_n;
  logic [20:0]                     minv;
  logic [3:0]                      hex_d;
  logic                            hex_ok;
  logic [15:0]                     code_h;
  logic [7:0]                      esc_v;
  logic                            esc_hit;
  logic [2:0]                      diff;

  always_comb begin
    state_o  = state_i;
    held_o   = held_i;
    fail     = 1'b0;
    fail_st  = jsu_pkg::ST_DATA;
    cnt      = '0;
    byt      = '0;
    lead_len = 3'd0;
    code_c   = {state_i.code[14:0], data_byte_i[5:0]};
    diff     = state_i.seq_len - {1'b0, state_i.seq_rem};
    idx      = diff[1:0];
    rem_n    = state_i.seq_rem - 2'd1;
    minv     = Min4;
    hex_d    = 4'd0;
    hex_ok   = 1'b0;
    code_h   = {state_i.code[11:0], 4'd0};
    esc_v    = 8'h00;
    esc_hit  = 1'b1;

    case (state_i.mode)
      // String body: plain bytes, escapes and UTF-8 lead bytes
      jsu_pkg::MODE_BODY: begin
        if (data_byte_i[7:5] == 3'b110) begin
          lead_len = 3'd2;
        end else if (data_byte_i[7:4] == 4'b1110) begin
          lead_len = 3'd3;
        end else if (data_byte_i[7:3] == 5'b11110) begin
          lead_len = 3'd4;
        end
        if (end_of_input_i) begin
          fail    = 1'b1;
          fail_st = jsu_pkg::ST_UNTERMINATED;
        end else if (data_byte_i == Quote) begin
          fail    = 1'b1;
          fail_st = jsu_pkg::ST_DONE;
        end else if (data_byte_i == Bslash) begin
          state_o.mode = jsu_pkg::MODE_ESC;
        end else if (data_byte_i < 8'h20 || data_byte_i == Del) begin
          fail    = 1'b1;
          fail_st = jsu_pkg::ST_CONTROL_BYTE;
        end else if (!data_byte_i[7]) begin
          cnt    = jsu_pkg::CountW'(1);
          byt[0] = data_byte_i;
        end else if (lead_len == 3'd0) begin
          fail    = 1'b1;
          fail_st = jsu_pkg::ST_BAD_UTF8;
        end else begin
          state_o.seq_len = lead_len;
          state_o.code    = {13'd0, data_byte_i & (Del >> lead_len)};
          state_o.seq_rem = 2'(lead_len - 3'd1);
          state_o.mode    = jsu_pkg::MODE_CONT;
          held_o[0]       = data_byte_i;
        end
      end

      // Continuation bytes of a raw multi-byte sequence
      jsu_pkg::MODE_CONT: begin
        if (state_i.seq_len == 3'd2) begin
          minv = Min2;
        end else if (state_i.seq_len == 3'd3) begin
          minv = Min3;
        end
        if (end_of_input_i || data_byte_i[7:6] != 2'b10) begin
          fail    = 1'b1;
          fail_st = jsu_pkg::ST_BAD_UTF8;
        end else begin
          state_o.code    = code_c;
          state_o.seq_rem = rem_n;
          if (rem_n != 2'd0) begin
            if (idx < 2'd3) begin
              held_o[idx] = data_byte_i;
            end
          end else if (code_c < minv || code_c > CodeMax ||
                       (code_c >= SurLo && code_c <= SurHi)) begin
            fail    = 1'b1;
            fail_st = jsu_pkg::ST_BAD_UTF8;
          end else begin
            // Release the held bytes, then the final byte
            for (int k = 0; k < 3; k++) begin
              if (3'(k) < state_i.seq_len - 3'd1) begin
                byt[k] = held_i[k];
              end
            end
            byt[2'(state_i.seq_len - 3'd1)] = data_byte_i;
            cnt          = jsu_pkg::CountW'(state_i.seq_len);
            state_o.mode = jsu_pkg::MODE_BODY;
          end
        end
      end

      // Byte after a backslash
      jsu_pkg::MODE_ESC: begin
        case (data_byte_i)
          Quote:   esc_v = Quote;
          Bslash:  esc_v = Bslash;
          Slash:   esc_v = Slash;
          8'h62:   esc_v = 8'h08;
          8'h66:   esc_v = 8'h0C;
          8'h6E:   esc_v = 8'h0A;
          8'h72:   esc_v = 8'h0D;
          8'h74:   esc_v = 8'h09;
          default: esc_hit = 1'b0;
        endcase
        if (end_of_input_i) begin
          fail    = 1'b1;
          fail_st = jsu_pkg::ST_DANGLING_ESC;
        end else if (data_byte_i == 8'h75) begin
          state_o.mode    = jsu_pkg::MODE_HEX;
          state_o.hex_cnt = 2'd0;
          state_o.code    = '0;
        end else if (esc_hit) begin
          cnt          = jsu_pkg::CountW'(1);
          byt[0]       = esc_v;
          state_o.mode = jsu_pkg::MODE_BODY;
        end else begin
          fail    = 1'b1;
          fail_st = jsu_pkg::ST_UNKNOWN_ESC;
        end
      end

      // Hex digits of a \u escape
      jsu_pkg::MODE_HEX: begin
        if (data_byte_i inside {[8'h30:8'h39]}) begin
          hex_d  = data_byte_i[3:0];
          hex_ok = 1'b1;
        end else if (data_byte_i inside {[8'h61:8'h66], [8'h41:8'h46]}) begin
          hex_d  = data_byte_i[3:0] + 4'd9;
          hex_ok = 1'b1;
        end
        code_h = {state_i.code[11:0], hex_d};
        if (end_of_input_i) begin
          fail    = 1'b1;
          fail_st = jsu_pkg::ST_TRUNCATED_U;
        end else if (!hex_ok) begin
          fail    = 1'b1;
          fail_st = jsu_pkg::ST_BAD_HEX;
        end else begin
          state_o.code = {5'd0, code_h};
          if (state_i.hex_cnt != 2'd3) begin
            state_o.hex_cnt = state_i.hex_cnt + 2'd1;
          end else begin
            state_o.hex_cnt = 2'd0;
            if ({5'd0, code_h} >= SurLo && {5'd0, code_h} <= SurHi) begin
              fail    = 1'b1;
              fail_st = jsu_pkg::ST_SURROGATE;
            end else begin
              state_o.mode = jsu_pkg::MODE_BODY;
              // Encode the code point as UTF-8
              if (code_h < 16'h0080) begin
                cnt    = jsu_pkg::CountW'(1);
                byt[0] = code_h[7:0];
              end else if (code_h < 16'h0800) begin
                cnt    = jsu_pkg::CountW'(2);
                byt[0] = {3'b110, code_h[10:6]};
                byt[1] = {2'b10, code_h[5:0]};
              end else begin
                cnt    = jsu_pkg::CountW'(3);
                byt[0] = {4'b1110, code_h[15:12]};
                byt[1] = {2'b10, code_h[11:6]};
                byt[2] = {2'b10, code_h[5:0]};
              end
            end
          end
        end
      end

      // Waiting for the opening quote
      default: begin
        if (!end_of_input_i && data_byte_i == Quote) begin
          state_o.mode = jsu_pkg::MODE_BODY;
        end else begin
          fail    = 1'b1;
          fail_st = jsu_pkg::ST_NO_OPEN;
        end
      end
    endcase

    // A done or error result stands alone and returns to idle
    if (fail) begin
      state_o.mode = jsu_pkg::MODE_IDLE;
      cnt          = jsu_pkg::CountW'(1);
      byt          = '0;
    end

    res_o.count = cnt;
    for (int k = 0; k < jsu_pkg::MaxResults; k++) begin
      res_o.item[k].out_byte = byt[k];
      res_o.item[k].status   = fail ? fail_st : jsu_pkg::ST_DATA;
      res_o.item[k].last     = (cnt != '0) &&
                               (jsu_pkg::CountW'(k) == cnt - jsu_pkg::CountW'(1));
    end
  end

endmodule

`default_nettype wire

@@ sv/jsu_res_fifo.sv @@
// Result queue: takes up to four results at once, delivers one per transaction.
`default_nettype none

module jsu_res_fifo #(
  parameter int Depth = jsu_pkg::ResDepthDefault
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 wr_en_i,
  input  jsu_pkg::res_bundle_t wr_i,
  output logic                 room_o,
  output logic                 rd_valid_o,
  input  logic                 rd_ready_i,
  output jsu_pkg::res_t        rd_o
);

  localparam int PtrW = $clog2(Depth);
  localparam int CntW = $clog2(Depth + 1);

  jsu_pkg::res_t [Depth-1:0]                   mem_q;
  logic [PtrW-1:0]                             wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0]                             rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0]                             count_q, count_d;
  logic [jsu_pkg::MaxResults-1:0][PtrW-1:0]    wr_idx;
  logic [PtrW:0]                               sum;
  logic [PtrW:0]                               ptr_sum;
  logic                                        pop;
  logic [CntW-1:0]                             n_wr;

  assign pop        = rd_valid_o && rd_ready_i;
  assign rd_valid_o = count_q != '0;
  assign rd_o       = mem_q[rd_ptr_q];
  assign room_o     = (CntW'(Depth) - count_q) >= CntW'(jsu_pkg::MaxResults);
  assign n_wr       = wr_en_i ? CntW'(wr_i.count) : '0;

  // Work out the wrapped slot of each incoming result
  always_comb begin
    sum = '0;
    for (int k = 0; k < jsu_pkg::MaxResults; k++) begin
      sum = {1'b0, wr_ptr_q} + (PtrW+1)'(k);
      if (sum >= (PtrW+1)'(Depth)) begin
        sum = sum - (PtrW+1)'(Depth);
      end
      wr_idx[k] = sum[PtrW-1:0];
    end
  end

  // Advance the pointers and the fill count
  always_comb begin
    ptr_sum = {1'b0, wr_ptr_q} + (PtrW+1)'(n_wr);
    if (ptr_sum >= (PtrW+1)'(Depth)) begin
      ptr_sum = ptr_sum - (PtrW+1)'(Depth);
    end
    wr_ptr_d = ptr_sum[PtrW-1:0];
    rd_ptr_d = rd_ptr_q;
    if (pop) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + PtrW'(1);
    end
    count_d = count_q + n_wr - CntW'(pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  // Store the results of a transaction
  always_ff @(posedge clk_i) begin
    for (int k = 0; k < jsu_pkg::MaxResults; k++) begin
      if (wr_en_i && jsu_pkg::CountW'(k) < wr_i.count) begin
        mem_q[wr_idx[k]] <= wr_i.item[k];
      end
    end
  end

endmodule

`default_nettype wire

@@ sv/json_string_unescaper_unit.sv @@
// Top level of the JSON string unescaper with strict UTF-8 checking.
//
//   channel  direction  handshake               payload
//   in       sink       in_valid_i / in_ready_o  data_byte_i, end_of_input_i
//   out      source     out_valid_o / out_ready_i out_byte_o, status_o, last_o
//
// One input byte is taken per cycle unless input stalls; it is decoded
// combinationally from the input register and written to the queue with room.
// The queue delivers one result per cycle while out_ready_i is high; input
// stalls only when the queue has fewer free slots than the four results one
// byte can cause. Reset returns the decoder to waiting for an opening quote
// and empties the queue; held sequence bytes are not cleared.
`default_nettype none

module json_string_unescaper_unit #(
  parameter int ResDepth = jsu_pkg::ResDepthDefault
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [7:0] data_byte_i,
  input  logic       end_of_input_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic [7:0] out_byte_o,
  output logic [3:0] status_o,
  output logic       last_o
);

  logic                 s1_valid_q, s1_valid_d;
  logic [7:0]           s1_byte_q;
  logic                 s1_eoi_q;
  logic                 s1_fire;
  logic                 in_fire;
  logic                 room;
  jsu_pkg::core_state_t state_q, state_d;
  logic [2:0][7:0]      held_q, held_d;
  jsu_pkg::res_bundle_t res;
  jsu_pkg::res_t        head;

  assign s1_fire    = s1_valid_q && room;
  assign in_ready_o = !s1_valid_q || room;
  assign in_fire    = in_valid_i && in_ready_o;
  assign s1_valid_d = in_fire || (s1_valid_q && !s1_fire);

  // Input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else begin
      s1_valid_q <= s1_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      s1_byte_q <= data_byte_i;
      s1_eoi_q  <= end_of_input_i;
    end
  end

  // Decoder state, updated when a byte is handed to the queue
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= '{mode: jsu_pkg::MODE_IDLE, default: '0};
    end else if (s1_fire) begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_fire) begin
      held_q <= held_d;
    end
  end

  jsu_decode u_decode (
    .state_i        (state_q),
    .held_i         (held_q),
    .data_byte_i    (s1_byte_q),
    .end_of_input_i (s1_eoi_q),
    .state_o        (state_d),
    .held_o         (held_d),
    .res_o          (res)
  );

  jsu_res_fifo #(
    .Depth (ResDepth)
  ) u_res_fifo (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .wr_en_i    (s1_fire),
    .wr_i       (res),
    .room_o     (room),
    .rd_valid_o (out_valid_o),
    .rd_ready_i (out_ready_i),
    .rd_o       (head)
  );

  assign out_byte_o = head.out_byte;
  assign status_o   = head.status;
  assign last_o     = head.last;

endmodule

`default_nettype wire

@@ sv/jsu_checker.sv @@
// Port-level checks on the unescaper's result channel, bound to the top level.
`default_nettype none
`include "assert_macros.svh"

module jsu_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       out_valid_o,
  input logic       out_ready_i,
  input logic [7:0] out_byte_o,
  input logic [3:0] status_o,
  input logic       last_o
);

  // Status codes stay within the defined set
  `JSU_ASSERT(a_status_range, !out_valid_o || status_o <= jsu_pkg::ST_BAD_UTF8, "status code out of range")

  // A done or error result always closes its transaction group
  `JSU_ASSERT(a_end_is_last, !(out_valid_o && status_o != jsu_pkg::ST_DATA) || last_o, "end result not marked last")

  // A done or error result carries no byte
  `JSU_ASSERT(a_end_byte_zero, !(out_valid_o && status_o != jsu_pkg::ST_DATA) || out_byte_o == 8'h00, "end result carries a byte")

  // Hold a stalled result
  `JSU_ASSERT_NEXT(a_out_hold, out_valid_o && !out_ready_i, out_valid_o && $stable(out_byte_o) && $stable(status_o) && $stable(last_o), "stalled result changed")

endmodule

bind json_string_unescaper_unit jsu_checker u_jsu_checker (.*);

`default_nettype wire
